// ===== src/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// types and codes shared by the sorted interval table and its checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sit_pkg;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_FIND   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_ALIGN    = 3'd3;
    localparam logic [2:0] ST_OVERLAP  = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic [11:0] PAGE_MASK = 12'hFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] addr;
        logic [31:0] end_addr;
        logic [7:0]  perm_flags;
        logic [31:0] tag;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] hit_start;
        logic [31:0] hit_end;
        logic [7:0]  hit_flags;
        logic [31:0] hit_tag;
        logic [8:0]  region_count;
    } t_out_word;

    typedef struct packed {
        logic [31:0] r_start;
        logic [31:0] r_end;
        logic [7:0]  r_flags;
        logic [31:0] r_tag;
    } t_entry;

endpackage

// ===== src/sorted_interval_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_interval_table_unit
// sorted table of non-overlapping address regions held in one memory
// ----------------------------------------------------------------------------
// Input words on i_in_* (valid/ready) carry clear, add, remove or find; each
// gives exactly one output word on o_out_* (valid/ready).
// Entries live in one synchronous memory, one registered read port, one write
// port. Find, remove and accepted adds walk entries one at a time.
// Clear, and add rejected as full, bad range or misaligned, go straight to the
// done state; find, remove and accepted adds scan every stored entry, and the
// scan issues one read a cycle. Remove moves each entry above the removed one
// down by one place; add moves each entry at or above the insert point up by
// one place, then writes the new region there.
// One word is worked on at a time; o_in_ready is high only while idle, and a
// result still waiting in the output register does not hold off the next word.
// Reset clears the count and control; the memory is not cleared, as only
// entries below the count are used.
// When the receiver stalls the result holds in the output register; the next
// word may be taken and worked on, and its result waits until the register
// is emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_interval_table_unit
    import sit_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SHWR  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    logic [2:0]    r_state;
    t_in_word      r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pos;
    logic          r_found;
    logic          r_ovl;
    t_entry        r_hit;
    logic          r_out_valid;
    t_out_word     r_out;
    logic [2:0]    r_status;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    logic [CW-1:0] last_idx;
    logic          in_last;
    logic [CW-1:0] idx_m1;
    assign idx_m1  = r_idx - CW'(1);
    assign last_idx = r_count - CW'(1);

    // read and write port controls for each state
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_rd;
        in_last = 1'b0;
        case (r_state)
            S_SCAN: begin
                rd_en = r_idx < r_count;
            end
            S_SHIFT: begin
                rd_en = 1'b1;
                if (r_req.action == ACT_ADD) begin
                    rd_addr = idx_m1[AW-1:0];
                end else begin
                    rd_addr = AW'(r_idx + CW'(1));
                end
            end
            S_SHWR: begin
                wr_en = 1'b1;
            end
            S_CHECK: begin
                if (r_req.action == ACT_ADD && !r_ovl && r_idx == r_pos) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = '{r_req.addr, r_req.end_addr, r_req.perm_flags, r_req.tag};
                end
            end
            default: begin
            end
        endcase
        in_last = (r_idx == last_idx);
    end

    // r_scan_v marks that r_rd holds entry r_scan_i
    logic          r_scan_v;
    logic [CW-1:0] r_scan_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_scan_v    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_scan_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_req    <= i_in_data;
                        r_idx    <= '0;
                        r_pos    <= r_count;
                        r_found  <= 1'b0;
                        r_ovl    <= 1'b0;
                        r_status <= ST_OK;
                        r_hit    <= '0;
                        case (i_in_data.action)
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            ACT_ADD: begin
                                if ({1'b0, r_count} >= (CW+1)'(DEPTH)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (i_in_data.addr >= i_in_data.end_addr) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if ((i_in_data.addr[11:0] & PAGE_MASK) != '0 ||
                                             (i_in_data.end_addr[11:0] & PAGE_MASK) != '0) begin
                                    r_status <= ST_ALIGN;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue read of r_idx, evaluate previous read
                    if (r_scan_v) begin
                        case (r_req.action)
                            ACT_ADD: begin
                                if (r_req.addr < r_rd.r_end && r_rd.r_start < r_req.end_addr)
                                    r_ovl <= 1'b1;
                                if (r_rd.r_start >= r_req.addr && r_pos == r_count)
                                    r_pos <= r_scan_i;
                            end
                            ACT_REMOVE: begin
                                if (r_rd.r_start == r_req.addr && !r_found) begin
                                    r_found <= 1'b1;
                                    r_pos   <= r_scan_i;
                                end
                            end
                            default: begin
                                if (r_rd.r_start <= r_req.addr) begin
                                    r_found <= r_req.addr < r_rd.r_end;
                                    r_hit   <= r_rd;
                                end
                            end
                        endcase
                    end
                    if (r_idx < r_count) begin
                        r_scan_v <= 1'b1;
                        r_scan_i <= r_idx;
                        r_idx    <= r_idx + CW'(1);
                    end else if (!r_scan_v) begin
                        r_state <= S_CHECK;
                        r_idx   <= r_count;
                    end
                end
                S_CHECK: begin
                    case (r_req.action)
                        ACT_ADD: begin
                            if (r_ovl) begin
                                r_status <= ST_OVERLAP;
                                r_state  <= S_DONE;
                            end else if (r_idx == r_pos) begin
                                r_count <= r_count + CW'(1);
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SHIFT;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!r_found) begin
                                r_status <= ST_NOTFOUND;
                                r_state  <= S_DONE;
                            end else begin
                                r_idx   <= r_pos;
                                r_state <= S_SHIFT;
                            end
                        end
                        default: begin
                            if (!r_found) begin
                                r_status <= ST_NOTFOUND;
                                r_hit    <= '0;
                            end
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (r_req.action == ACT_REMOVE && (in_last || r_count == '0)) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    if (r_req.action == ACT_ADD) begin
                        r_idx   <= idx_m1;
                        r_state <= S_CHECK;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SHIFT;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid        <= 1'b1;
                        r_out.status       <= r_status;
                        r_out.hit_start    <= r_hit.r_start;
                        r_out.hit_end      <= r_hit.r_end;
                        r_out.hit_flags    <= r_hit.r_flags;
                        r_out.hit_tag      <= r_hit.r_tag;
                        r_out.region_count <= 9'(r_count);
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/sit_checker.sv =====
// ----------------------------------------------------------------------------
// sit_checker
// port-level checks on the sorted interval table, bound to the table module
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sit_checker
    import sit_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output word changed while stalled")
    `ASSERT_IMPL(a_status_legal, i_clk, i_rst_n, o_out_valid, o_out_data.status <= ST_NOTFOUND, "illegal status")
    `ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_OK, o_out_data.hit_end == '0 && o_out_data.hit_tag == '0, "hit fields not zero on miss")
    `ASSERT_NEXT(a_one_at_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second word accepted during work")

endmodule

bind sorted_interval_table_unit sit_checker u_sit_checker (.*);
